FILE: src/top_k_rating_tracker_assert.svh
// assertion macros for the top k rating tracker checker
// expects i_clk and i_rst_n in the scope of use
`ifndef TOP_K_RATING_TRACKER_ASSERT_SVH
`define TOP_K_RATING_TRACKER_ASSERT_SVH

// same-cycle implication
`define TKRT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tkrt_pkg.sv
// shared types, field widths and codes of the top k rating tracker
// no dependencies
`timescale 1ns / 1ps

package tkrt_pkg;

    localparam int VOTES_W  = 32;
    localparam int RATING_W = 7;
    localparam int YEAR_W   = 12;
    localparam int TITLE_W  = 20;
    localparam int RANK_W   = 7;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;

    localparam logic [VOTES_W-1:0] MIN_VOTES_RESET = 32'd100000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_BELOW_MIN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_BETTER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVICTED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_DONE   = 3'd4;

    typedef struct packed {
        logic [VOTES_W-1:0]  votes;
        logic [RATING_W-1:0] rating;
        logic [YEAR_W-1:0]   year;
        logic [TITLE_W-1:0]  title_id;
    } t_entry;

    typedef struct packed {
        logic                load_item;
        logic                rd_en;
        logic                wr_en;
        logic                wr_new;
        logic                cnt_inc;
        logic                res_load;
        logic                res_entry;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic              op_read;
        logic              below_min;
        logic              rank_hit;
        logic              beats;
        logic [RANK_W-1:0] rank;
    } t_dp_stat;

    // a ranks strictly above b: higher rating, or same rating and more votes
    function automatic logic ranks_above(input t_entry a, input t_entry b);
        return {a.rating, a.votes} > {b.rating, b.votes};
    endfunction

endpackage

FILE: src/tkrt_item_if.sv
// request channel of the top k rating tracker
// depends on tkrt_pkg
`timescale 1ns / 1ps

interface tkrt_item_if;
    import tkrt_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [RANK_W-1:0]   rank;
    logic [VOTES_W-1:0]  votes;
    logic [RATING_W-1:0] rating;
    logic [YEAR_W-1:0]   year;
    logic [TITLE_W-1:0]  title_id;

    modport source (output valid, opcode, rank, votes, rating, year, title_id,
                    input ready);
    modport sink   (input valid, opcode, rank, votes, rating, year, title_id,
                    output ready);
endinterface

FILE: src/tkrt_result_if.sv
// result channel of the top k rating tracker
// depends on tkrt_pkg
`timescale 1ns / 1ps

interface tkrt_result_if;
    import tkrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                entry_valid;
    logic [VOTES_W-1:0]  out_votes;
    logic [RATING_W-1:0] out_rating;
    logic [YEAR_W-1:0]   out_year;
    logic [TITLE_W-1:0]  out_title_id;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, status, entry_valid, out_votes, out_rating,
                    out_year, out_title_id, fill_count, input ready);
    modport sink   (input valid, status, entry_valid, out_votes, out_rating,
                    out_year, out_title_id, fill_count, output ready);
endinterface

FILE: src/tkrt_cfg_if.sv
// configuration write channel carrying the min_votes register
// depends on tkrt_pkg
`timescale 1ns / 1ps

interface tkrt_cfg_if;
    import tkrt_pkg::*;

    logic               valid;
    logic               ready;
    logic [VOTES_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: src/tkrt_dp.sv
// datapath: request register, sorted entry memory, count, result registers
// depends on tkrt_pkg
`timescale 1ns / 1ps

module tkrt_dp #(
    parameter int CAPACITY = 100,
    parameter int IDX_W    = 7,
    parameter int CNT_W    = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tkrt_pkg::t_dp_cmd             i_cmd,
    input  logic [IDX_W-1:0]              i_rd_addr,
    input  logic [IDX_W-1:0]              i_wr_addr,
    input  logic                          i_opcode,
    input  logic [tkrt_pkg::RANK_W-1:0]   i_rank,
    input  logic [tkrt_pkg::VOTES_W-1:0]  i_votes,
    input  logic [tkrt_pkg::RATING_W-1:0] i_rating,
    input  logic [tkrt_pkg::YEAR_W-1:0]   i_year,
    input  logic [tkrt_pkg::TITLE_W-1:0]  i_title_id,
    input  logic                          i_cfg_we,
    input  logic [tkrt_pkg::VOTES_W-1:0]  i_cfg_data,
    output tkrt_pkg::t_dp_stat            o_stat,
    output logic [CNT_W-1:0]              o_count,
    output logic [tkrt_pkg::STATUS_W-1:0] o_status,
    output logic                          o_entry_valid,
    output tkrt_pkg::t_entry              o_entry,
    output logic [tkrt_pkg::FILL_W-1:0]   o_fill_count
);
    import tkrt_pkg::*;

    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    logic [VOTES_W-1:0]  r_min_votes;
    logic [CNT_W-1:0]    r_count;
    logic                r_op;
    logic [RANK_W-1:0]   r_rank;
    t_entry              r_item;
    t_entry              r_mem [CAPACITY];
    t_entry              r_rd_data;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_valid;
    t_entry              r_res_entry;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_valid;
    t_entry              r_out_entry;
    logic [FILL_W-1:0]   r_out_fill;
    t_entry              n_wr_data;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_votes <= MIN_VOTES_RESET;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_votes <= i_cfg_data;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op            <= i_opcode;
            r_rank          <= i_rank;
            r_item.votes    <= i_votes;
            r_item.rating   <= i_rating;
            r_item.year     <= i_year;
            r_item.title_id <= i_title_id;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_valid  <= i_cmd.res_entry;
            r_res_entry  <= i_cmd.res_entry ? r_rd_data : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_valid  <= r_res_valid;
            r_out_entry  <= r_res_entry;
            r_out_fill   <= FILL_W'(r_count);
        end
    end

    assign n_wr_data = i_cmd.wr_new ? r_item : r_rd_data;

    // sorted entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= n_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_stat.op_read   = (r_op == OP_READ);
    assign o_stat.below_min = (r_item.votes < r_min_votes);
    assign o_stat.rank_hit  = (CMP_W'(r_rank) < CMP_W'(r_count));
    assign o_stat.beats     = ranks_above(r_item, r_rd_data);
    assign o_stat.rank      = r_rank;

    assign o_count       = r_count;
    assign o_status      = r_out_status;
    assign o_entry_valid = r_out_valid;
    assign o_entry       = r_out_entry;
    assign o_fill_count  = r_out_fill;

endmodule

FILE: src/tkrt_ctrl.sv
// controller: request handshake, insert scan sequencing, result handshake
// depends on tkrt_pkg
`timescale 1ns / 1ps

module tkrt_ctrl #(
    parameter int CAPACITY = 100,
    parameter int IDX_W    = 7,
    parameter int CNT_W    = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  tkrt_pkg::t_dp_stat i_stat,
    input  logic [CNT_W-1:0]   i_count,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output tkrt_pkg::t_dp_cmd  o_cmd,
    output logic [IDX_W-1:0]   o_rd_addr,
    output logic [IDX_W-1:0]   o_wr_addr
);
    import tkrt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_RDOUT  = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_PLACE0 = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam int LAST_IDX = CAPACITY - 1;
    localparam int SCAN_TOP = (CAPACITY > 1) ? CAPACITY - 2 : 0;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_rd_addr   = r_idx;
        o_wr_addr   = IDX_W'(r_idx + 1'b1);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op_read) begin
                    if (i_stat.rank_hit) begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = IDX_W'(i_stat.rank);
                        n_state     = S_RDOUT;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_READ_DONE;
                        n_state          = S_DONE;
                    end
                end else if (i_stat.below_min) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_BELOW_MIN;
                    n_state          = S_DONE;
                end else if (i_count == CNT_W'(CAPACITY)) begin
                    // compare against the current minimum first
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = IDX_W'(LAST_IDX);
                    n_state     = S_CHK;
                end else begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_INSERTED;
                    o_cmd.cnt_inc    = 1'b1;
                    if (i_count == '0) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_new = 1'b1;
                        o_wr_addr    = '0;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = IDX_W'(i_count - 1'b1);
                        n_idx       = IDX_W'(i_count - 1'b1);
                        n_state     = S_SCAN;
                    end
                end
            end
            S_RDOUT: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_entry  = 1'b1;
                o_cmd.res_status = ST_READ_DONE;
                n_state          = S_DONE;
            end
            S_CHK: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.beats) begin
                    o_cmd.res_status = ST_EVICTED;
                    if (CAPACITY == 1) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_new = 1'b1;
                        o_wr_addr    = '0;
                        n_state      = S_DONE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = IDX_W'(SCAN_TOP);
                        n_idx       = IDX_W'(SCAN_TOP);
                        n_state     = S_SCAN;
                    end
                end else begin
                    o_cmd.res_status = ST_NOT_BETTER;
                    n_state          = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.beats) begin
                    // move the held entry one rank down
                    if (r_idx == '0) begin
                        n_state = S_PLACE0;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = IDX_W'(r_idx - 1'b1);
                        n_idx       = IDX_W'(r_idx - 1'b1);
                    end
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_PLACE0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_new = 1'b1;
                o_wr_addr    = '0;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: src/top_k_rating_tracker.sv
// top level of the top k rating tracker: controller plus datapath
// depends on tkrt_pkg, the channel interfaces, tkrt_ctrl and tkrt_dp
`timescale 1ns / 1ps

// Keeps the best CAPACITY records sorted by rating, then votes (rank 0 best).
// i_item carries one request: opcode 0 inserts a record, opcode 1 reads the
// entry at rank. Each request gives exactly one result on o_result with a
// status code, the entry read (zero on inserts and misses) and the fill count.
// i_cfg writes the min_votes register; it is always ready and is meant to be
// written while no request is in flight.
// One request at a time: i_item.ready is high only while the block is idle.
// An insert moves each held entry that it outranks one rank down, one entry
// per cycle through the write and registered read port of the entry memory.
// The next request is taken at the same edge at which the result can first
// be taken.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver holds the block in its final step only.
// Synchronous active-low reset empties the store (count zero) and loads
// min_votes with 100000; the memory contents are not cleared.
module top_k_rating_tracker #(
    parameter int CAPACITY = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tkrt_item_if.sink            i_item,
    tkrt_result_if.source        o_result,
    tkrt_cfg_if.sink             i_cfg
);
    import tkrt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_wr_addr;
    logic [CNT_W-1:0] w_count;
    t_entry           w_entry;

    assign i_cfg.ready = 1'b1;

    tkrt_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (w_stat),
        .i_count     (w_count),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr)
    );

    tkrt_dp #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .i_wr_addr     (w_wr_addr),
        .i_opcode      (i_item.opcode),
        .i_rank        (i_item.rank),
        .i_votes       (i_item.votes),
        .i_rating      (i_item.rating),
        .i_year        (i_item.year),
        .i_title_id    (i_item.title_id),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_stat        (w_stat),
        .o_count       (w_count),
        .o_status      (o_result.status),
        .o_entry_valid (o_result.entry_valid),
        .o_entry       (w_entry),
        .o_fill_count  (o_result.fill_count)
    );

    assign o_result.out_votes    = w_entry.votes;
    assign o_result.out_rating   = w_entry.rating;
    assign o_result.out_year     = w_entry.year;
    assign o_result.out_title_id = w_entry.title_id;

endmodule

FILE: src/tkrt_checker.sv
// port-level checker of the top k rating tracker, bound to the top level
// depends on tkrt_pkg and top_k_rating_tracker_assert.svh
`timescale 1ns / 1ps

`include "top_k_rating_tracker_assert.svh"

module tkrt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tkrt_pkg::STATUS_W-1:0] i_status,
    input logic                          i_entry_valid,
    input logic [tkrt_pkg::VOTES_W-1:0]  i_out_votes,
    input logic [tkrt_pkg::RATING_W-1:0] i_out_rating,
    input logic [tkrt_pkg::FILL_W-1:0]   i_fill_count
);
    import tkrt_pkg::*;

    logic w_out_stall;
    logic w_in_take;

    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_in_take   = i_in_valid && i_in_ready;

    // one request in flight at a time
    `TKRT_ASSERT_NEXT(a_busy_after_take, w_in_take, !i_in_ready,
        "request taken while the previous one is still in work")

    // a stalled result holds
    `TKRT_ASSERT_NEXT(a_result_holds, w_out_stall,
        i_out_valid && $stable(i_status) && $stable(i_fill_count),
        "stalled result changed")

    // only reads return an entry
    `TKRT_ASSERT_NOW(a_entry_only_on_read, i_out_valid && i_entry_valid,
        i_status == ST_READ_DONE, "entry returned on an insert result")

    // a result without an entry carries zero entry fields
    `TKRT_ASSERT_NOW(a_no_entry_zero, i_out_valid && !i_entry_valid,
        i_out_votes == '0 && i_out_rating == '0,
        "entry fields not zero on a result without entry")

endmodule

bind top_k_rating_tracker tkrt_checker u_tkrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_status      (o_result.status),
    .i_entry_valid (o_result.entry_valid),
    .i_out_votes   (o_result.out_votes),
    .i_out_rating  (o_result.out_rating),
    .i_fill_count  (o_result.fill_count)
);
